### design/median_of_value_set_macros.svh
// assertion macros for the median block checkers
`ifndef MEDIAN_OF_VALUE_SET_MACROS_SVH
`define MEDIAN_OF_VALUE_SET_MACROS_SVH

// property must hold at every clock edge outside reset
`define MOVS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define MOVS_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

### design/movs_pkg.sv
// ----------------------------------------------------------------------------
// movs_pkg
// Shared constants and types for the median of value set block.
// ----------------------------------------------------------------------------
`default_nettype none

package movs_pkg;

    localparam int MAX_ITEMS_DEF  = 1024;
    localparam int VALUE_BITS_DEF = 16;
    localparam int QUEUE_DEPTH    = 4;

    // head of the item queue as seen by the back part
    typedef struct packed {
        logic avail;
        logic last;
    } movs_qhead_t;

endpackage

`default_nettype wire

### design/movs_front.sv
// ----------------------------------------------------------------------------
// movs_front
// Accepts items from the command port and holds them in a short queue
// until the back part takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module movs_front
    import movs_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [VALUE_BITS-1:0] value,
    input  wire logic                  last,
    output logic                       busy,
    output movs_qhead_t                head,
    output logic [VALUE_BITS-1:0]      head_value,
    input  wire logic                  pop
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [VALUE_BITS-1:0] val_q [QUEUE_DEPTH];
    logic                  last_q [QUEUE_DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic          push;
    logic          do_pop;

    assign busy   = (fill_reg == CW'(QUEUE_DEPTH));
    assign push   = start && !busy;
    assign do_pop = pop && (fill_reg != '0);

    assign head.avail = (fill_reg != '0);
    assign head.last  = last_q[rd_ptr_reg];
    assign head_value = val_q[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push   ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        fill_next   = fill_reg + CW'(push) - CW'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            val_q[wr_ptr_reg]  <= value;
            last_q[wr_ptr_reg] <= last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

`default_nettype wire

### design/movs_back.sv
// ----------------------------------------------------------------------------
// movs_back
// Stores values in the value memory and, when a set closes, finds the
// median by a bitwise selection: one memory scan per value bit, counting
// entries under the current prefix, and a second selection for an even count.
// ----------------------------------------------------------------------------
`default_nettype none

module movs_back
    import movs_pkg::*;
#(
    parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire movs_qhead_t           head,
    input  wire logic [VALUE_BITS-1:0] head_value,
    output logic                       pop,
    output logic                       done,
    output logic [VALUE_BITS:0]        median_doubled,
    output logic [$clog2(MAX_ITEMS+1)-1:0] set_count,
    output logic                       overflow
);

    localparam int VB = VALUE_BITS;
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int BW = (VB > 1) ? $clog2(VB) : 1;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic [VB-1:0] mem [MAX_ITEMS];
    logic [VB-1:0] rdata_reg;

    logic          state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          drop_reg, drop_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] hits_reg, hits_next;
    logic [CW-1:0] addr_reg, addr_next;
    logic          rdv_reg, rdv_next;
    logic [BW-1:0] bit_reg, bit_next;
    logic [VB-1:0] prefix_reg, prefix_next;
    logic          second_reg, second_next;
    logic [VB-1:0] first_reg, first_next;
    logic          done_reg, done_next;
    logic [VB:0]   med_reg, med_next;
    logic [CW-1:0] scnt_reg, scnt_next;
    logic          ovf_reg, ovf_next;

    logic          we;
    logic          rd_en;
    logic [VB:0]   sel_bit;
    logic [VB:0]   low_mask;
    logic          match;
    logic [VB-1:0] p_new;
    logic [CW-1:0] n_new;

    assign done           = done_reg;
    assign median_doubled = med_reg;
    assign set_count      = scnt_reg;
    assign overflow       = ovf_reg;

    // entry counts if it shares the prefix above the bit and has a zero at the bit
    assign sel_bit  = (VB+1)'(1) << bit_reg;
    assign low_mask = (sel_bit << 1) - (VB+1)'(1);
    assign match    = (((rdata_reg ^ prefix_reg) & ~low_mask[VB-1:0]) == '0)
                      && !rdata_reg[bit_reg];
    assign rd_en    = (state_reg == S_SCAN) && (addr_reg < n_reg);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        drop_next   = drop_reg;
        n_next      = n_reg;
        k_next      = k_reg;
        hits_next   = hits_reg;
        addr_next   = addr_reg;
        rdv_next    = 1'b0;
        bit_next    = bit_reg;
        prefix_next = prefix_reg;
        second_next = second_reg;
        first_next  = first_reg;
        done_next   = 1'b0;
        med_next    = med_reg;
        scnt_next   = scnt_reg;
        ovf_next    = ovf_reg;
        pop         = 1'b0;
        we          = 1'b0;
        p_new       = prefix_reg;
        n_new       = cnt_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (head.avail)
                begin
                    pop = 1'b1;
                    if (cnt_reg < CW'(MAX_ITEMS))
                    begin
                        we    = 1'b1;
                        n_new = cnt_reg + CW'(1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    cnt_next = n_new;
                    if (head.last)
                    begin
                        n_next      = n_new;
                        k_next      = n_new >> 1;
                        bit_next    = BW'(VB - 1);
                        prefix_next = '0;
                        hits_next   = '0;
                        addr_next   = '0;
                        second_next = 1'b0;
                        state_next  = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (rd_en)
                begin
                    rdv_next  = 1'b1;
                    addr_next = addr_reg + CW'(1);
                end
                if (rdv_reg && match)
                    hits_next = hits_reg + CW'(1);
                if (!rd_en && !rdv_reg)
                begin
                    // scan of this bit finished: settle the bit
                    if (k_reg < hits_reg)
                        p_new = prefix_reg;
                    else
                    begin
                        p_new  = prefix_reg | sel_bit[VB-1:0];
                        k_next = k_reg - hits_reg;
                    end
                    prefix_next = p_new;
                    addr_next   = '0;
                    hits_next   = '0;
                    if (bit_reg != '0)
                        bit_next = bit_reg - BW'(1);
                    else if (!n_reg[0] && !second_reg)
                    begin
                        // even count: also fetch the lower middle value
                        first_next  = p_new;
                        second_next = 1'b1;
                        k_next      = (n_reg >> 1) - CW'(1);
                        bit_next    = BW'(VB - 1);
                        prefix_next = '0;
                    end
                    else
                    begin
                        if (n_reg[0])
                            med_next = {p_new, 1'b0};
                        else
                            med_next = {1'b0, first_reg} + {1'b0, p_new};
                        scnt_next  = n_reg;
                        ovf_next   = drop_reg;
                        done_next  = 1'b1;
                        cnt_next   = '0;
                        drop_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[cnt_reg[AW-1:0]] <= head_value;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rdata_reg <= mem[addr_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        k_reg      <= k_next;
        hits_reg   <= hits_next;
        addr_reg   <= addr_next;
        bit_reg    <= bit_next;
        prefix_reg <= prefix_next;
        second_reg <= second_next;
        first_reg  <= first_next;
        med_reg    <= med_next;
        scnt_reg   <= scnt_next;
        ovf_reg    <= ovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            drop_reg  <= 1'b0;
            rdv_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            drop_reg  <= drop_next;
            rdv_reg   <= rdv_next;
            done_reg  <= done_next;
        end
    end

endmodule

`default_nettype wire

### design/median_of_value_set.sv
// ----------------------------------------------------------------------------
// median_of_value_set
// Collects a set of unsigned values and reports twice their median.
// ----------------------------------------------------------------------------
//  channel | handshake       | payload
//  --------+-----------------+---------------------------------------
//  item    | start / busy    | value, last
//  result  | done (strobe)   | median_doubled, set_count, overflow
//
// one item per cycle is taken while the queue has room; the back part
// stores one value per cycle while it is not scanning. a closing item starts
// a selection of VALUE_BITS memory scans, twice for an even count.
// results appear on done for one cycle and cannot be stalled.
// reset is asynchronous, active low, and empties queue and count.
`default_nettype none

module median_of_value_set
    import movs_pkg::*;
#(
    parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [VALUE_BITS-1:0] value,
    input  wire logic                  last,
    output logic                       done,
    output logic [VALUE_BITS:0]        median_doubled,
    output logic [$clog2(MAX_ITEMS+1)-1:0] set_count,
    output logic                       overflow
);

    movs_qhead_t           head;
    logic [VALUE_BITS-1:0] head_value;
    logic                  pop;

    movs_front #(.VALUE_BITS(VALUE_BITS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .value      (value),
        .last       (last),
        .busy       (busy),
        .head       (head),
        .head_value (head_value),
        .pop        (pop)
    );

    movs_back #(.MAX_ITEMS(MAX_ITEMS), .VALUE_BITS(VALUE_BITS)) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .head_value     (head_value),
        .pop            (pop),
        .done           (done),
        .median_doubled (median_doubled),
        .set_count      (set_count),
        .overflow       (overflow)
    );

endmodule

`default_nettype wire

### design/movs_checker.sv
// ----------------------------------------------------------------------------
// movs_checker
// Port-level checks on the median block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "median_of_value_set_macros.svh"

module movs_checker #(
    parameter int MAX_ITEMS  = 1024,
    parameter int VALUE_BITS = 16
)
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  start,
    input wire logic                  busy,
    input wire logic                  done,
    input wire logic [VALUE_BITS:0]   median_doubled,
    input wire logic [$clog2(MAX_ITEMS+1)-1:0] set_count
,   input wire logic                  overflow
);

    // a set always holds at least one value
    `MOVS_NEVER(a_count_nonzero, clk, rst_n, done && (set_count == '0), "empty set reported")

    // selection takes many cycles, so results never come back to back
    `MOVS_ASSERT(a_done_single, clk, rst_n, done |=> !done, "results on consecutive cycles")

    // values are dropped only once the store is full
    `MOVS_ASSERT(a_ovf_full, clk, rst_n,
                 (done && overflow) |-> (set_count == ($clog2(MAX_ITEMS+1))'(MAX_ITEMS)),
                 "overflow with room left")

    // handshake lines are always driven
    `MOVS_NEVER(a_ctrl_known, clk, rst_n, $isunknown({start, busy, done}), "unknown handshake")

    // a result beat carries fully known fields
    `MOVS_NEVER(a_result_known, clk, rst_n,
                done && $isunknown({median_doubled, set_count, overflow}),
                "unknown result field")

endmodule

bind median_of_value_set movs_checker #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_BITS (VALUE_BITS)
) u_movs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .median_doubled (median_doubled),
    .set_count      (set_count),
    .overflow       (overflow)
);

`default_nettype wire
